// ===== design/canrxq_pkg.sv =====
// Shared types and constants for the CAN receive queue.
// Used by the controller, the datapath and the top level.
package canrxq_pkg;

    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_PEEK      = 3'd2;
    localparam logic [2:0] CMD_FLUSH     = 3'd3;
    localparam logic [2:0] CMD_TX_DONE   = 3'd4;
    localparam logic [2:0] CMD_STAT_CLR  = 3'd5;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int FLAGS_W = 2;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 32;
    localparam int PCT_W   = 7;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              remote;
        logic              extended;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
        logic [ID_W-1:0]   id;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic load;
        logic exec;
        logic calc;
        logic resp;
    } t_ctrl_cmd;

endpackage

// ===== design/canrxq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module canrxq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/canrxq_ctrl.sv =====
// Command sequencer of the CAN receive queue.
// Depends on canrxq_pkg for the datapath command struct.
module canrxq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    output canrxq_pkg::t_ctrl_cmd o_cmd
);
    import canrxq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                o_cmd.resp = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== design/canrxq_dp.sv =====
// Datapath of the CAN receive queue: frame RAM, ring indices, statistics
// and fill-level scaling. Depends on canrxq_pkg and canrxq_ram.
module canrxq_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  canrxq_pkg::t_ctrl_cmd               i_cmd,
    input  logic [canrxq_pkg::CMD_W-1:0]        i_command,
    input  logic [canrxq_pkg::ID_W-1:0]         i_frame_id,
    input  logic [canrxq_pkg::LEN_W-1:0]        i_frame_length,
    input  logic [canrxq_pkg::DATA_W-1:0]       i_frame_data,
    input  logic                                i_frame_extended,
    input  logic                                i_frame_remote,
    input  logic [canrxq_pkg::TIME_W-1:0]       i_time_ms,
    input  logic                                i_tx_ok,
    output logic                                o_strobe,
    output logic                                o_found,
    output logic [canrxq_pkg::ID_W-1:0]         o_out_frame_id,
    output logic [canrxq_pkg::LEN_W-1:0]        o_out_frame_length,
    output logic [canrxq_pkg::DATA_W-1:0]       o_out_frame_data,
    output logic [canrxq_pkg::FLAGS_W-1:0]      o_out_frame_flags,
    output logic [canrxq_pkg::TIME_W-1:0]       o_out_time_ms,
    output logic [canrxq_pkg::PCT_W-1:0]        o_usage_percent,
    output logic [canrxq_pkg::STAT_W-1:0]       o_received_count,
    output logic [canrxq_pkg::STAT_W-1:0]       o_sent_count,
    output logic [canrxq_pkg::STAT_W-1:0]       o_fault_count,
    output logic [canrxq_pkg::TIME_W-1:0]       o_activity_ms
);
    import canrxq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NB = $clog2(100 * DEPTH);
    localparam int SH = NB + AW;
    localparam int MB = NB + 1;
    localparam longint unsigned RECIP = ((64'd1 << SH) + DEPTH - 1) / DEPTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_LOW = AW'(DEPTH);

    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_data;
    logic              r_ext;
    logic              r_rem;
    logic [TIME_W-1:0] r_now;
    logic              r_tx_ok;

    logic [AW-1:0]     r_wr_idx;
    logic [AW-1:0]     r_rd_idx;
    logic [STAT_W-1:0] r_rx_total;
    logic [STAT_W-1:0] r_tx_total;
    logic [STAT_W-1:0] r_fault_total;
    logic [TIME_W-1:0] r_activity;
    logic              r_found;
    logic [PCT_W-1:0]  r_usage;

    logic              w_push;
    logic              w_read;
    logic              w_nonempty;
    logic [AW-1:0]     w_wr_next;
    logic [AW-1:0]     w_rd_next;
    logic [AW-1:0]     w_count;
    logic [NB-1:0]     w_cnt_ext;
    logic [NB-1:0]     w_scaled;
    logic [NB+MB-1:0]  w_prod;
    logic [MB-1:0]     w_recip;
    t_slot             w_wslot;
    t_slot             w_rslot;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        next_slot = (idx == LAST_SLOT) ? '0 : idx + AW'(1);
    endfunction

    assign w_wr_next  = next_slot(r_wr_idx);
    assign w_rd_next  = next_slot(r_rd_idx);
    assign w_nonempty = (r_wr_idx != r_rd_idx);
    assign w_push     = i_cmd.exec && (r_cmd == CMD_PUSH);
    assign w_read     = i_cmd.exec && w_nonempty &&
                        ((r_cmd == CMD_POP) || (r_cmd == CMD_PEEK));

    assign w_wslot.stamp    = r_now;
    assign w_wslot.remote   = r_rem;
    assign w_wslot.extended = r_ext;
    assign w_wslot.length   = r_len;
    assign w_wslot.data     = r_data;
    assign w_wslot.id       = r_id;

    canrxq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wr_idx),
        .i_wdata (w_wslot),
        .i_re    (w_read),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rslot)
    );

    // count * 100 by shift-add, then exact divide by DEPTH via reciprocal
    assign w_count   = (r_wr_idx >= r_rd_idx) ? (r_wr_idx - r_rd_idx)
                                              : (r_wr_idx + DEPTH_LOW - r_rd_idx);
    assign w_cnt_ext = NB'(w_count);
    assign w_scaled  = (w_cnt_ext << 6) + (w_cnt_ext << 5) + (w_cnt_ext << 2);
    assign w_recip   = RECIP[MB-1:0];
    assign w_prod    = {{MB{1'b0}}, w_scaled} * {{NB{1'b0}}, w_recip};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_id    <= i_frame_id;
            r_len   <= i_frame_length;
            r_data  <= i_frame_data;
            r_ext   <= i_frame_extended;
            r_rem   <= i_frame_remote;
            r_now   <= i_time_ms;
            r_tx_ok <= i_tx_ok;
        end
        if (i_cmd.calc) begin
            r_usage <= w_prod[SH +: PCT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_rx_total    <= '0;
            r_tx_total    <= '0;
            r_fault_total <= '0;
            r_activity    <= '0;
            r_found       <= 1'b0;
        end else if (i_cmd.exec) begin
            r_found <= w_read;
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (w_wr_next == r_rd_idx) begin
                        r_rd_idx      <= w_rd_next;
                        r_fault_total <= r_fault_total + STAT_W'(1);
                    end
                    r_wr_idx   <= w_wr_next;
                    r_rx_total <= r_rx_total + STAT_W'(1);
                    r_activity <= r_now;
                end
                CMD_POP: begin
                    if (w_nonempty) begin
                        r_rd_idx <= w_rd_next;
                    end
                end
                CMD_FLUSH: begin
                    r_wr_idx <= '0;
                    r_rd_idx <= '0;
                end
                CMD_TX_DONE: begin
                    if (r_tx_ok) begin
                        r_tx_total <= r_tx_total + STAT_W'(1);
                        r_activity <= r_now;
                    end else begin
                        r_fault_total <= r_fault_total + STAT_W'(1);
                    end
                end
                CMD_STAT_CLR: begin
                    r_rx_total    <= '0;
                    r_tx_total    <= '0;
                    r_fault_total <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe           = i_cmd.resp;
    assign o_found            = r_found;
    assign o_out_frame_id     = r_found ? w_rslot.id : '0;
    assign o_out_frame_length = r_found ? w_rslot.length : '0;
    assign o_out_frame_data   = r_found ? w_rslot.data : '0;
    assign o_out_frame_flags  = r_found ? {w_rslot.remote, w_rslot.extended} : '0;
    assign o_out_time_ms      = r_found ? w_rslot.stamp : '0;
    assign o_usage_percent    = r_usage;
    assign o_received_count   = r_rx_total;
    assign o_sent_count       = r_tx_total;
    assign o_fault_count      = r_fault_total;
    assign o_activity_ms      = r_activity;

endmodule

// ===== design/can_receive_fifo_with_statistics.sv =====
// CAN receive queue with statistics: top level.
// Depends on canrxq_pkg, canrxq_ctrl, canrxq_dp (and canrxq_ram).
//
// Usage:
//   Drive a command and its frame fields and raise start while busy is low;
//   the item is taken at that clock edge. Commands: push, pop, peek, flush,
//   transmit done, statistics reset; codes six and seven only report status.
//   Exactly one result follows each item: o_strobe is high for one cycle,
//   after the exec and calc states, and all result ports are valid
//   in that cycle. The receiver cannot stall; it must take the result then.
//   busy stays high from the accepting edge until the strobe cycle ends, so
//   no item is taken until the last result is out. The four steps are the
//   sequencer passes: capture, ring access with its registered RAM read,
//   fill-level scaling through one multiplier, and the result cycle.
//   The ring holds DEPTH slots, DEPTH-1 usable; a push into a full ring
//   drops the oldest frame and counts an error.
//   Reset (synchronous, active low) empties the ring and clears all counts
//   and the activity time; the frame RAM is not cleared and needs no pass.
module can_receive_fifo_with_statistics #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [canrxq_pkg::CMD_W-1:0]        i_command,
    input  logic [canrxq_pkg::ID_W-1:0]         i_frame_id,
    input  logic [canrxq_pkg::LEN_W-1:0]        i_frame_length,
    input  logic [canrxq_pkg::DATA_W-1:0]       i_frame_data,
    input  logic                                i_frame_extended,
    input  logic                                i_frame_remote,
    input  logic [canrxq_pkg::TIME_W-1:0]       i_time_ms,
    input  logic                                i_tx_ok,
    output logic                                o_strobe,
    output logic                                o_found,
    output logic [canrxq_pkg::ID_W-1:0]         o_out_frame_id,
    output logic [canrxq_pkg::LEN_W-1:0]        o_out_frame_length,
    output logic [canrxq_pkg::DATA_W-1:0]       o_out_frame_data,
    output logic [canrxq_pkg::FLAGS_W-1:0]      o_out_frame_flags,
    output logic [canrxq_pkg::TIME_W-1:0]       o_out_time_ms,
    output logic [canrxq_pkg::PCT_W-1:0]        o_usage_percent,
    output logic [canrxq_pkg::STAT_W-1:0]       o_received_count,
    output logic [canrxq_pkg::STAT_W-1:0]       o_sent_count,
    output logic [canrxq_pkg::STAT_W-1:0]       o_fault_count,
    output logic [canrxq_pkg::TIME_W-1:0]       o_activity_ms
);
    import canrxq_pkg::*;

    t_ctrl_cmd w_cmd;

    canrxq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    canrxq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_command          (i_command),
        .i_frame_id         (i_frame_id),
        .i_frame_length     (i_frame_length),
        .i_frame_data       (i_frame_data),
        .i_frame_extended   (i_frame_extended),
        .i_frame_remote     (i_frame_remote),
        .i_time_ms          (i_time_ms),
        .i_tx_ok            (i_tx_ok),
        .o_strobe           (o_strobe),
        .o_found            (o_found),
        .o_out_frame_id     (o_out_frame_id),
        .o_out_frame_length (o_out_frame_length),
        .o_out_frame_data   (o_out_frame_data),
        .o_out_frame_flags  (o_out_frame_flags),
        .o_out_time_ms      (o_out_time_ms),
        .o_usage_percent    (o_usage_percent),
        .o_received_count   (o_received_count),
        .o_sent_count       (o_sent_count),
        .o_fault_count      (o_fault_count),
        .o_activity_ms      (o_activity_ms)
    );

endmodule
